[rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands for the channel credit table RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: implication");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

// condition never holds
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("assertion failed: forbidden condition");

`endif

[rtl/cct_pkg.sv]
// ---------------------------------------------------------------------------
// cct_pkg
// Shared types and codes of the channel credit table.
// ---------------------------------------------------------------------------
package cct_pkg;

	localparam int ID_W = 31;
	localparam logic [ID_W-1:0] ID_RESET = 31'd100;

	localparam logic [1:0] OP_OPEN    = 2'd0;
	localparam logic [1:0] OP_CONSUME = 2'd1;
	localparam logic [1:0] OP_CLOSE   = 2'd2;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NO_FREE   = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;
	localparam logic [1:0] ST_TOO_SMALL = 2'd3;

	typedef struct packed {
		logic [1:0]      operation;
		logic [ID_W-1:0] channel_id;
		logic [ID_W-1:0] initial_window;
		logic [ID_W-1:0] byte_count;
	} req_t;

	typedef struct packed {
		logic [1:0]      status;
		logic [ID_W-1:0] value;
		logic [4:0]      active_count;
	} rsp_t;

	// broadcast from the controller to every cell
	typedef struct packed {
		logic            cmp;
		logic            apply;
		req_t            req;
		logic [ID_W-1:0] new_id;
	} cmd_t;

	// handed from each cell to its upper neighbor
	typedef struct packed {
		logic            taken;
		logic            ok;
		logic [ID_W-1:0] value;
	} link_t;

endpackage

[rtl/cct_cell.sv]
// ---------------------------------------------------------------------------
// cct_cell
// One slot of the table: open flag, channel id and credit window, with
// local compare stage and a claim link to the next cell.
// ---------------------------------------------------------------------------
module cct_cell import cct_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  cmd_t  cmd,
	input  link_t link_in,
	output link_t link_out
);

	logic            open_q;
	logic [ID_W-1:0] id_q;
	logic [ID_W-1:0] win_q;

	logic            hit_s1;
	logic            free_s1;
	logic            ge_s1;
	logic [ID_W-1:0] diff_s1;

	logic want;
	logic mine;

	always_ff @(posedge clk) begin
		if (cmd.cmp) begin
			hit_s1  <= open_q && (id_q == cmd.req.channel_id);
			free_s1 <= !open_q;
			ge_s1   <= (win_q >= cmd.req.byte_count);
			diff_s1 <= win_q - cmd.req.byte_count;
		end
	end

	always_comb begin
		case (cmd.req.operation)
			OP_OPEN:    want = free_s1;
			OP_CONSUME: want = hit_s1;
			OP_CLOSE:   want = hit_s1;
			default:    want = 1'b0;
		endcase
	end

	assign mine = cmd.apply && want && !link_in.taken;

	always_comb begin
		if (link_in.taken) begin
			link_out = link_in;
		end else begin
			link_out.taken = want;
			link_out.ok    = want && ((cmd.req.operation != OP_CONSUME) || ge_s1);
			link_out.value = (want && (cmd.req.operation == OP_CONSUME) && ge_s1) ?
				diff_s1 : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= 1'b0;
		end else if (mine) begin
			if (cmd.req.operation == OP_OPEN) begin
				open_q <= 1'b1;
			end else if (cmd.req.operation == OP_CLOSE) begin
				open_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mine) begin
			if (cmd.req.operation == OP_OPEN) begin
				id_q  <= cmd.new_id;
				win_q <= cmd.req.initial_window;
			end else if ((cmd.req.operation == OP_CONSUME) && ge_s1) begin
				win_q <= diff_s1;
			end
		end
	end

endmodule

[rtl/channel_credit_table.sv]
// ---------------------------------------------------------------------------
// channel_credit_table
// Fixed table of channel slots with open, consume and close requests.
// Built as a row of slot cells; the lowest claiming cell wins via a
// claim link passed from cell to cell.
// ---------------------------------------------------------------------------
//  channel | direction | payload | handshake
//  req     | in        | req_t   | req_valid / req_stall
//  rsp     | out       | rsp_t   | rsp_valid / rsp_stall
//
//  Each request first runs the per-cell id and window compares, which are
//  registered, then the claim along the cell row and the slot update.
//  A new request is taken in the cycle its predecessor resolves.
//  The response register holds while rsp_stall is high; a pending request
//  waits for it and req_stall stays high meanwhile.
//  Reset clears all open flags, the count and sets the next id to 100.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module channel_credit_table import cct_pkg::*; #(
	parameter int SLOT_COUNT = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	localparam int CNT_W = $clog2(SLOT_COUNT + 1);

	req_t             req_q;
	logic             v1_q;
	logic             v2_q;
	logic             rsp_valid_q;
	rsp_t             rsp_q;
	logic [CNT_W-1:0] count_q;
	logic [ID_W-1:0]  next_id_q;

	logic             resolve;
	logic             accept;
	cmd_t             cmd;
	link_t            link [0:SLOT_COUNT];
	link_t            last;
	logic [CNT_W-1:0] count_next;
	logic [CNT_W+4:0] count_ext;
	logic [1:0]       status;
	logic [ID_W-1:0]  value;
	logic             opened;
	logic             closed;

	assign resolve   = v2_q && (!rsp_valid_q || !rsp_stall);
	assign req_stall = v1_q || (v2_q && !resolve);
	assign accept    = req_valid && !req_stall;

	assign cmd.cmp    = v1_q;
	assign cmd.apply  = resolve;
	assign cmd.req    = req_q;
	assign cmd.new_id = next_id_q;

	assign link[0] = '0;

	for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
		cct_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cmd      (cmd),
			.link_in  (link[i]),
			.link_out (link[i+1])
		);
	end

	assign last   = link[SLOT_COUNT];
	assign opened = (req_q.operation == OP_OPEN) && last.taken;
	assign closed = (req_q.operation == OP_CLOSE) && last.taken;

	always_comb begin
		status = ST_OK;
		value  = '0;
		case (req_q.operation)
			OP_OPEN: begin
				status = last.taken ? ST_OK : ST_NO_FREE;
				value  = last.taken ? next_id_q : '0;
			end
			OP_CONSUME: begin
				if (!last.taken) begin
					status = ST_NOT_FOUND;
				end else if (!last.ok) begin
					status = ST_TOO_SMALL;
				end else begin
					value = last.value;
				end
			end
			OP_CLOSE: begin
				status = last.taken ? ST_OK : ST_NOT_FOUND;
			end
			default: begin
				status = ST_OK;
			end
		endcase
	end

	always_comb begin
		count_next = count_q;
		if (opened) begin
			count_next = count_q + 1'b1;
		end else if (closed) begin
			count_next = count_q - 1'b1;
		end
	end

	assign count_ext = {5'b0, count_next};

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
		end
		if (resolve) begin
			rsp_q.status       <= status;
			rsp_q.value        <= value;
			rsp_q.active_count <= count_ext[4:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q        <= 1'b0;
			v2_q        <= 1'b0;
			rsp_valid_q <= 1'b0;
			count_q     <= '0;
			next_id_q   <= ID_RESET;
		end else begin
			v1_q <= accept;
			if (v1_q) begin
				v2_q <= 1'b1;
			end else if (resolve) begin
				v2_q <= 1'b0;
			end
			if (resolve) begin
				rsp_valid_q <= 1'b1;
				count_q     <= count_next;
				if (opened) begin
					next_id_q <= next_id_q + 1'b1;
				end
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`ASSERT_NEVER(a_one_stage_busy, clk, arst_n, v1_q && v2_q)
	`ASSERT_IMPL(a_count_bound, clk, arst_n, 1'b1, count_q <= CNT_W'(SLOT_COUNT))
	`ASSERT_NEXT(a_id_only_on_resolve, clk, arst_n, !resolve, $stable(next_id_q))
	`ASSERT_NEXT(a_accept_to_compare, clk, arst_n, accept, v1_q && !v2_q)

endmodule
